FILE: rtl/suws_pkg.sv
// Shared types, constants, command and status codes for the sorted unique word set.
// No dependencies; imported by the cell, the top level and the testbench.
package suws_pkg;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned WORD_BYTES = 20;
  localparam int unsigned WORD_W     = 160;

  typedef logic [WORD_W-1:0] word_t;

  // Bytes beyond WORD_BYTES are forced to zero; byte 0 sits in the top bits.
  localparam word_t WORD_MASK = {WORD_W{1'b1}} << (8 * (20 - WORD_BYTES));

  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_EMIT   = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_INSERTED  = 2'd0;
  localparam status_t ST_DUPLICATE = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_EMITTED   = 2'd3;

  typedef struct packed {
    logic cmp_en;    // register compare flags against the broadcast word
    logic ins_en;    // open a gap and take the new word
    logic shift_en;  // move every word one place towards the head
  } cell_ctrl_t;

endpackage

FILE: rtl/suws_cell.sv
// One place of the sorted chain: a stored word, its valid bit and its compare flags.
// Depends on suws_pkg.
module suws_cell
  import suws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  word_t      cmp_word_i,
  input  word_t      new_word_i,
  input  word_t      prev_word_i,
  input  logic       prev_valid_i,
  input  logic       prev_ins_i,
  input  word_t      next_word_i,
  input  logic       next_valid_i,
  output word_t      word_o,
  output logic       valid_o,
  output logic       ins_o,
  output logic       eq_o
);

  word_t word_q;
  logic  valid_q, gt_q, eq_q;

  assign ins_o   = !valid_q || gt_q;
  assign word_o  = word_q;
  assign valid_o = valid_q;
  assign eq_o    = eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      gt_q <= valid_q && (word_q > cmp_word_i);
      eq_q <= valid_q && (word_q == cmp_word_i);
    end else if (ctrl_i.ins_en) begin
      if (ins_o) begin
        valid_q <= valid_q | prev_valid_i;
      end
    end else if (ctrl_i.shift_en) begin
      valid_q <= next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en && ins_o) begin
      // take the left neighbour's word while the gap is further left
      word_q <= prev_ins_i ? prev_word_i : new_word_i;
    end else if (ctrl_i.shift_en) begin
      word_q <= next_word_i;
    end
  end

endmodule

FILE: rtl/sorted_unique_word_set.sv
// Sorted unique word set: a chain of CAPACITY cells kept in ascending order.
// Depends on suws_pkg and suws_cell.
//
// Input channel (in_valid_i/in_ready_o) carries one beat per command:
// action_i 0 inserts the zero-padded word on word_high_i/middle_i/low_i,
// action_i 1 emits all stored words in ascending order and clears the set.
// Output channel (out_valid_o/out_ready_i) carries result beats from an
// output register.
// Insert: the beat is accepted only when the block is idle; every cell
// compares its word with the incoming one in the accept cycle, and once the
// output register is free the chain opens a gap and takes the word (or drops
// it as a duplicate or because the set is full). One result beat per insert;
// no new beat is taken until the chain update is done, and the chain update
// waits for the output register.
// Emit: one word leaves the head per cycle while the receiver keeps up, as
// the chain shifts towards the head, so n stored words give n beats, the
// last marked by last_o; an empty set gives one beat with is_empty_o.
// A stalled receiver holds the output register and freezes the chain.
// Reset clears every valid bit, so the set starts empty.
module sorted_unique_word_set
  import suws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [63:0] word_high_i,
  input  logic [63:0] word_middle_i,
  input  logic [31:0] word_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_high_o,
  output logic [63:0] out_middle_o,
  output logic [31:0] out_low_o,
  output logic [1:0]  status_o,
  output logic        is_empty_o,
  output logic        last_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INSERT = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state_q, state_d;
  word_t      in_word, new_word_q;
  cell_ctrl_t ctrl;
  logic       accept, out_free, load;

  word_t   word_arr  [CAPACITY+1];
  logic    valid_arr [CAPACITY+1];
  logic    ins_arr   [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  word_t   res_word_d, res_word_q;
  status_t res_status_d, res_status_q;
  logic    res_empty_d, res_empty_q, res_last_d, res_last_q;
  logic    out_valid_q;

  assign in_word    = {word_high_i, word_middle_i, word_low_i} & WORD_MASK;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // padding place past the tail reads as empty
  assign word_arr[CAPACITY]  = '0;
  assign valid_arr[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t prev_word;
    logic  prev_valid, prev_ins, cell_eq;
    if (i == 0) begin : g_head
      assign prev_word  = '0;
      assign prev_valid = 1'b1;
      assign prev_ins   = 1'b0;
    end else begin : g_body
      assign prev_word  = word_arr[i-1];
      assign prev_valid = valid_arr[i-1];
      assign prev_ins   = ins_arr[i-1];
    end

    suws_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmp_word_i   (in_word),
      .new_word_i   (new_word_q),
      .prev_word_i  (prev_word),
      .prev_valid_i (prev_valid),
      .prev_ins_i   (prev_ins),
      .next_word_i  (word_arr[i+1]),
      .next_valid_i (valid_arr[i+1]),
      .word_o       (word_arr[i]),
      .valid_o      (valid_arr[i]),
      .ins_o        (ins_arr[i]),
      .eq_o         (cell_eq)
    );
    assign eq_vec[i] = cell_eq;
  end

  always_comb begin
    state_d      = state_q;
    ctrl         = '0;
    load         = 1'b0;
    res_word_d   = '0;
    res_status_d = ST_INSERTED;
    res_empty_d  = 1'b0;
    res_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctrl.cmp_en = (action_i == ACTION_INSERT);
          state_d     = (action_i == ACTION_EMIT) ? S_EMIT : S_INSERT;
        end
      end
      S_INSERT: begin
        if (out_free) begin
          load = 1'b1;
          if (|eq_vec) begin
            res_status_d = ST_DUPLICATE;
          end else if (valid_arr[CAPACITY-1]) begin
            res_status_d = ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        res_status_d = ST_EMITTED;
        if (out_free) begin
          load = 1'b1;
          if (!valid_arr[0]) begin
            res_empty_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            res_word_d    = word_arr[0];
            res_last_d    = !valid_arr[1];
            ctrl.shift_en = 1'b1;
            if (!valid_arr[1]) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_word_q <= in_word;
    end
    if (load) begin
      res_word_q   <= res_word_d;
      res_status_q <= res_status_d;
      res_empty_q  <= res_empty_d;
      res_last_q   <= res_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_high_o   = res_word_q[159:96];
  assign out_middle_o = res_word_q[95:32];
  assign out_low_o    = res_word_q[31:0];
  assign status_o     = res_status_q;
  assign is_empty_o   = res_empty_q;
  assign last_o       = res_last_q;

endmodule
